// File: rtl/link_health_circuit_breaker_top_assert.svh
// ----------------------------------------------------------------------------
// link health circuit breaker assertion macros
// concurrent checks that are left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef LINK_HEALTH_CIRCUIT_BREAKER_TOP_ASSERT_SVH
`define LINK_HEALTH_CIRCUIT_BREAKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define LHCB_ASSERT(label_, clk_, rstn_, prop_) \
  label_: assert property (@(posedge clk_) disable iff (!(rstn_)) (prop_)) \
    else $error("lhcb assertion failed");
// condition never seen outside reset
`define LHCB_ASSERT_NEVER(label_, clk_, rstn_, cond_) \
  label_: assert property (@(posedge clk_) disable iff (!(rstn_)) !(cond_)) \
    else $error("lhcb forbidden condition seen");
`else
`define LHCB_ASSERT(label_, clk_, rstn_, prop_)
`define LHCB_ASSERT_NEVER(label_, clk_, rstn_, cond_)
`endif

`endif

// File: rtl/lhcb_pkg.sv
// ----------------------------------------------------------------------------
// lhcb_pkg
// shared types, codes and widths of the link health circuit breaker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhcb_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned ELAPSED_W      = 16;
  localparam int unsigned ATT_W          = 8;
  localparam int unsigned LAT_W          = 17;
  localparam int unsigned OUT_CNT_W      = 16;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  // doublings never exceed sixteen, so five bits of iteration budget suffice
  localparam int unsigned BO_ITER_BITS   = 5;

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ATTEMPT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUCCESS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ENABLED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INITIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_THRESHOLD  = 3'd4;

  typedef enum logic [2:0] {
    LS_DISABLED     = 3'd0,
    LS_DISCONNECTED = 3'd1,
    LS_CONNECTING   = 3'd2,
    LS_CONNECTED    = 3'd3,
    LS_RECONNECTING = 3'd4,
    LS_FAULTED      = 3'd5
  } link_state_e;

  typedef enum logic [1:0] {
    BR_CLOSED   = 2'd0,
    BR_OPEN     = 2'd1,
    BR_HALFOPEN = 2'd2
  } breaker_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_BACKOFF = 2'd1,
    ST_EMIT    = 2'd2
  } lhcb_fsm_e;

  typedef struct packed {
    logic busy;
    logic done;
  } bo_status_t;

endpackage

`default_nettype wire

// File: rtl/lhcb_backoff.sv
// ----------------------------------------------------------------------------
// lhcb_backoff
// iterative capped exponential backoff: one compare and shift per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "link_health_circuit_breaker_top_assert.svh"

module lhcb_backoff #(
  parameter int unsigned COUNT_BITS = lhcb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [COUNT_BITS-1:0]       run_i,
  input  wire logic [lhcb_pkg::CFG_W-1:0]  first_i,
  input  wire logic [lhcb_pkg::CFG_W-1:0]  max_i,
  output logic      [lhcb_pkg::CFG_W-1:0]  delay_o,
  output lhcb_pkg::bo_status_t             status_o
);
  import lhcb_pkg::*;

  logic                    busy_q, busy_d;
  logic                    zero_q, zero_d;
  logic [CFG_W-1:0]        d_q, d_d;
  logic [CFG_W-1:0]        cap_q, cap_d;
  logic [BO_ITER_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0]   run_m1;
  logic                    finish;
  logic                    at_half;

  assign run_m1  = run_i - COUNT_BITS'(1);
  assign at_half = d_q >= (cap_q >> 1);
  assign finish  = busy_q && (zero_q || rem_q == '0 || at_half);

  // start load, then the compare and shift step until done
  always_comb begin
    busy_d = busy_q;
    zero_d = zero_q;
    d_d    = d_q;
    cap_d  = cap_q;
    rem_d  = rem_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        zero_d = (first_i == '0) || (run_i == '0);
        d_d    = first_i;
        cap_d  = (max_i > first_i) ? max_i : first_i;
        if ((run_m1 >> BO_ITER_BITS) != '0) begin
          rem_d = '1;
        end else begin
          rem_d = run_m1[BO_ITER_BITS-1:0];
        end
      end
    end else if (finish) begin
      busy_d = 1'b0;
    end else begin
      d_d   = d_q << 1;
      rem_d = rem_q - BO_ITER_BITS'(1);
    end
  end

  always_comb begin
    if (zero_q) begin
      delay_o = '0;
    end else if (rem_q == '0) begin
      delay_o = d_q;
    end else begin
      delay_o = cap_q;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    d_q    <= d_d;
    cap_q  <= cap_d;
    rem_q  <= rem_d;
  end

  `LHCB_ASSERT(a_bo_below_cap, clk_i, rst_ni, busy_q |-> (d_q <= cap_q))
  `LHCB_ASSERT(a_bo_keeps_going, clk_i, rst_ni, (busy_q && !finish) |=> busy_q)
  `LHCB_ASSERT(a_bo_done_frees, clk_i, rst_ni, finish |=> !busy_q)

endmodule

`default_nettype wire

// File: rtl/link_health_circuit_breaker_top.sv
// ----------------------------------------------------------------------------
// link_health_circuit_breaker_top
// link health tracker with circuit breaker and capped exponential backoff
// ----------------------------------------------------------------------------
// flow: an accepted transaction goes from the idle state to the emit state, which
//   loads the result register once it is free; a failure event waits first in the
//   backoff state for the backoff unit; a new event is taken only in the
//   idle state, so a failure holds off the next event until the doubling loop ends
// reset: control, link state and counters clear at once; configuration
//   registers take their defaults; there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "link_health_circuit_breaker_top_assert.svh"

module link_health_circuit_breaker_top #(
  parameter int unsigned COUNT_BITS = lhcb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lhcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lhcb_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lhcb_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [lhcb_pkg::ATT_W-1:0]      attempt_count_i,
  input  wire logic signed [lhcb_pkg::LAT_W-1:0] latency_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 allowed_o,
  output logic [2:0]                           link_state_o,
  output logic [1:0]                           breaker_state_o,
  output logic                                 is_online_o,
  output logic [lhcb_pkg::OUT_CNT_W-1:0]       failure_run_o,
  output logic [lhcb_pkg::OUT_CNT_W-1:0]       reconnects_o,
  output logic [lhcb_pkg::CFG_W-1:0]           retry_delay_o,
  output logic [lhcb_pkg::ATT_W-1:0]           last_attempts_o,
  output logic signed [lhcb_pkg::LAT_W-1:0]    last_latency_o
);
  import lhcb_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  // configuration
  logic             en_q;
  logic [CFG_W-1:0] bo_first_q, bo_max_q, cooldown_q, trip_q;

  // link state
  lhcb_fsm_e              fsm_q, fsm_d;
  link_state_e            conn_q, conn_d;
  breaker_e               brk_q, brk_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic                   online_q, online_d;
  logic [COUNT_BITS-1:0]  fail_q, fail_d;
  logic [COUNT_BITS-1:0]  recon_q, recon_d;
  logic [CFG_W-1:0]       delay_q, delay_d;
  logic [ATT_W-1:0]       att_q, att_d;
  logic [LAT_W-1:0]       lat_q, lat_d;
  logic                   allowed_q, allowed_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   out_allowed_q;
  logic [2:0]             out_link_q;
  logic [1:0]             out_brk_q;
  logic                   out_online_q;
  logic [OUT_CNT_W-1:0]   out_fail_q, out_recon_q;
  logic [CFG_W-1:0]       out_delay_q;
  logic [ATT_W-1:0]       out_att_q;
  logic [LAT_W-1:0]       out_lat_q;

  logic                   in_fire;
  logic                   bo_start;
  logic                   out_load;
  logic                   fail_event;
  logic [LAT_W-1:0]       lat_in;
  logic [COUNT_BITS-1:0]  fail_inc;
  logic [CFG_W-1:0]       thr;
  logic [CMP_W-1:0]       fail_inc_x, thr_x, fail_x, recon_x;
  logic [CFG_W-1:0]       bo_delay;
  bo_status_t             bo_status;

  assign in_fire    = in_valid_i && in_ready_o;
  assign fail_event = (kind_i == KIND_FAIL) && en_q;

  // any negative latency collapses to the all-ones value
  assign lat_in     = latency_i[LAT_W-1] ? '1 : latency_i;
  assign fail_inc   = (fail_q == '1) ? fail_q : fail_q + COUNT_BITS'(1);
  assign thr        = (trip_q == '0) ? CFG_W'(1) : trip_q;
  assign fail_inc_x = CMP_W'(fail_inc);
  assign thr_x      = CMP_W'(thr);
  assign fail_x     = CMP_W'(fail_q);
  assign recon_x    = CMP_W'(recon_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b1;
      bo_first_q <= '0;
      bo_max_q   <= '0;
      cooldown_q <= '0;
      trip_q     <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_ENABLED:  en_q       <= cfg_wdata_i[0];
        CFG_BACKOFF_INITIAL: bo_first_q <= cfg_wdata_i;
        CFG_BACKOFF_MAX:     bo_max_q   <= cfg_wdata_i;
        CFG_COOLDOWN_TICKS:  cooldown_q <= cfg_wdata_i;
        CFG_TRIP_THRESHOLD:  trip_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lhcb_backoff #(
    .COUNT_BITS(COUNT_BITS)
  ) u_backoff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bo_start),
    .run_i    (fail_d),
    .first_i  (bo_first_q),
    .max_i    (bo_max_q),
    .delay_o  (bo_delay),
    .status_o (bo_status)
  );

  // event update
  always_comb begin
    conn_d    = conn_q;
    brk_d     = brk_q;
    elapsed_d = elapsed_q;
    online_d  = online_q;
    fail_d    = fail_q;
    recon_d   = recon_q;
    delay_d   = delay_q;
    att_d     = att_q;
    lat_d     = lat_q;
    allowed_d = allowed_q;
    if (in_fire) begin
      allowed_d = 1'b0;
      if (kind_i == KIND_TICK && elapsed_q != '1) begin
        elapsed_d = elapsed_q + ELAPSED_W'(1);
      end
      if (kind_i <= KIND_FAIL && !en_q) begin
        conn_d   = LS_DISABLED;
        online_d = 1'b0;
      end else if (kind_i == KIND_CHECK) begin
        if (brk_q != BR_OPEN) begin
          allowed_d = 1'b1;
        end else if (elapsed_q >= cooldown_q) begin
          brk_d     = BR_HALFOPEN;
          allowed_d = 1'b1;
        end else begin
          conn_d   = LS_FAULTED;
          online_d = 1'b0;
        end
      end else if (kind_i == KIND_ATTEMPT) begin
        conn_d = (fail_q != '0) ? LS_RECONNECTING : LS_CONNECTING;
      end else if (kind_i == KIND_SUCCESS) begin
        online_d = 1'b1;
        conn_d   = LS_CONNECTED;
        fail_d   = '0;
        att_d    = attempt_count_i;
        lat_d    = lat_in;
        delay_d  = '0;
        brk_d    = BR_CLOSED;
      end else if (kind_i == KIND_FAIL) begin
        if (online_q || fail_q == '0) begin
          recon_d = (recon_q == '1) ? recon_q : recon_q + COUNT_BITS'(1);
        end
        online_d = 1'b0;
        fail_d   = fail_inc;
        att_d    = attempt_count_i;
        lat_d    = lat_in;
        if (fail_inc_x >= thr_x || brk_q == BR_HALFOPEN) begin
          if (brk_q != BR_OPEN) begin
            elapsed_d = '0;
          end
          brk_d  = BR_OPEN;
          conn_d = LS_FAULTED;
        end else begin
          brk_d  = BR_CLOSED;
          conn_d = LS_RECONNECTING;
        end
      end
    end
    if (bo_status.done) begin
      delay_d = bo_delay;
    end
  end

  // sequencer next state
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      ST_IDLE: begin
        if (in_fire) begin
          fsm_d = fail_event ? ST_BACKOFF : ST_EMIT;
        end
      end
      ST_BACKOFF: begin
        if (bo_status.done) begin
          fsm_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          fsm_d = ST_IDLE;
        end
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    bo_start   = 1'b0;
    out_load   = 1'b0;
    case (fsm_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        bo_start   = in_valid_i && fail_event;
      end
      ST_BACKOFF: ;
      ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      conn_q      <= LS_DISCONNECTED;
      brk_q       <= BR_CLOSED;
      elapsed_q   <= '0;
      online_q    <= 1'b0;
      fail_q      <= '0;
      recon_q     <= '0;
      delay_q     <= '0;
      att_q       <= '0;
      lat_q       <= '0;
      allowed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      conn_q      <= conn_d;
      brk_q       <= brk_d;
      elapsed_q   <= elapsed_d;
      online_q    <= online_d;
      fail_q      <= fail_d;
      recon_q     <= recon_d;
      delay_q     <= delay_d;
      att_q       <= att_d;
      lat_q       <= lat_d;
      allowed_q   <= allowed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // snapshot into the result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_allowed_q <= allowed_q;
      out_link_q    <= en_q ? conn_q : LS_DISABLED;
      out_brk_q     <= brk_q;
      out_online_q  <= online_q & en_q;
      out_fail_q    <= fail_x[OUT_CNT_W-1:0];
      out_recon_q   <= recon_x[OUT_CNT_W-1:0];
      out_delay_q   <= delay_q;
      out_att_q     <= att_q;
      out_lat_q     <= lat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign allowed_o       = out_allowed_q;
  assign link_state_o    = out_link_q;
  assign breaker_state_o = out_brk_q;
  assign is_online_o     = out_online_q;
  assign failure_run_o   = out_fail_q;
  assign reconnects_o    = out_recon_q;
  assign retry_delay_o   = out_delay_q;
  assign last_attempts_o = out_att_q;
  assign last_latency_o  = out_lat_q;

  `LHCB_ASSERT(a_emit_loads, clk_i, rst_ni, out_load |=> (out_valid_q && fsm_q == ST_IDLE))
  `LHCB_ASSERT(a_success_closes, clk_i, rst_ni,
    (in_fire && kind_i == KIND_SUCCESS && en_q) |=> (fail_q == '0 && brk_q == BR_CLOSED))
  `LHCB_ASSERT(a_fail_backs_off, clk_i, rst_ni,
    (in_fire && fail_event) |=> (fsm_q == ST_BACKOFF && bo_status.busy))
  `LHCB_ASSERT_NEVER(a_no_stray_done, clk_i, rst_ni, bo_status.done && fsm_q != ST_BACKOFF)

endmodule

`default_nettype wire
